// File: hw/rtl/sha_pkg.sv
// sha_pkg: shared types, constants and functions of the sha-256 stream hasher
// round constants, initial hash values, sigma functions, sequencer states
// no dependencies
package sha_pkg;

  typedef logic [31:0] sha_word_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] WIDX_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha_state_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       sched_step;
    logic       expand;
    logic [5:0] rnd;
    logic       wv_load;
    logic       wv_step;
    logic       hv_add;
    logic       hv_init;
    logic [2:0] widx;
  } sha_ctl_t;

  function automatic sha_word_t bsig0(input sha_word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic sha_word_t bsig1(input sha_word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic sha_word_t ssig0(input sha_word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic sha_word_t ssig1(input sha_word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic sha_word_t init_h(input logic [2:0] idx);
    sha_word_t v;
    case (idx)
      3'd0: v = 32'h6A09E667;
      3'd1: v = 32'hBB67AE85;
      3'd2: v = 32'h3C6EF372;
      3'd3: v = 32'hA54FF53A;
      3'd4: v = 32'h510E527F;
      3'd5: v = 32'h9B05688C;
      3'd6: v = 32'h1F83D9AB;
      default: v = 32'h5BE0CD19;
    endcase
    return v;
  endfunction

  function automatic sha_word_t round_k(input logic [5:0] idx);
    sha_word_t v;
    case (idx)
      6'd0:  v = 32'h428A2F98;
      6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hB5C0FBCF;
      6'd3:  v = 32'hE9B5DBA5;
      6'd4:  v = 32'h3956C25B;
      6'd5:  v = 32'h59F111F1;
      6'd6:  v = 32'h923F82A4;
      6'd7:  v = 32'hAB1C5ED5;
      6'd8:  v = 32'hD807AA98;
      6'd9:  v = 32'h12835B01;
      6'd10: v = 32'h243185BE;
      6'd11: v = 32'h550C7DC3;
      6'd12: v = 32'h72BE5D74;
      6'd13: v = 32'h80DEB1FE;
      6'd14: v = 32'h9BDC06A7;
      6'd15: v = 32'hC19BF174;
      6'd16: v = 32'hE49B69C1;
      6'd17: v = 32'hEFBE4786;
      6'd18: v = 32'h0FC19DC6;
      6'd19: v = 32'h240CA1CC;
      6'd20: v = 32'h2DE92C6F;
      6'd21: v = 32'h4A7484AA;
      6'd22: v = 32'h5CB0A9DC;
      6'd23: v = 32'h76F988DA;
      6'd24: v = 32'h983E5152;
      6'd25: v = 32'hA831C66D;
      6'd26: v = 32'hB00327C8;
      6'd27: v = 32'hBF597FC7;
      6'd28: v = 32'hC6E00BF3;
      6'd29: v = 32'hD5A79147;
      6'd30: v = 32'h06CA6351;
      6'd31: v = 32'h14292967;
      6'd32: v = 32'h27B70A85;
      6'd33: v = 32'h2E1B2138;
      6'd34: v = 32'h4D2C6DFC;
      6'd35: v = 32'h53380D13;
      6'd36: v = 32'h650A7354;
      6'd37: v = 32'h766A0ABB;
      6'd38: v = 32'h81C2C92E;
      6'd39: v = 32'h92722C85;
      6'd40: v = 32'hA2BFE8A1;
      6'd41: v = 32'hA81A664B;
      6'd42: v = 32'hC24B8B70;
      6'd43: v = 32'hC76C51A3;
      6'd44: v = 32'hD192E819;
      6'd45: v = 32'hD6990624;
      6'd46: v = 32'hF40E3585;
      6'd47: v = 32'h106AA070;
      6'd48: v = 32'h19A4C116;
      6'd49: v = 32'h1E376C08;
      6'd50: v = 32'h2748774C;
      6'd51: v = 32'h34B0BCB5;
      6'd52: v = 32'h391C0CB3;
      6'd53: v = 32'h4ED8AA4A;
      6'd54: v = 32'h5B9CCA4F;
      6'd55: v = 32'h682E6FF3;
      6'd56: v = 32'h748F82EE;
      6'd57: v = 32'h78A5636F;
      6'd58: v = 32'h84C87814;
      6'd59: v = 32'h8CC70208;
      6'd60: v = 32'h90BEFFFA;
      6'd61: v = 32'hA4506CEB;
      6'd62: v = 32'hBEF9A3F7;
      default: v = 32'hC67178F2;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/sha_if.sv
// sha_if: valid/ready channel interfaces of the sha-256 stream hasher
// input beats carry kind and data_byte, output beats carry one digest word
// depends on sha_pkg
interface sha_in_if;
  import sha_pkg::*;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
  import sha_pkg::*;
  logic      valid;
  logic      ready;
  sha_word_t digest_word;
  logic [2:0] word_index;
  logic      last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/sha256_stream_hasher.sv
// sha256_stream_hasher: sha-256 over a byte stream, one round per cycle
// sequencer, length and fill counters; instantiates sha_sched and sha_round
// depends on sha_pkg and sha_if
//
//  channel  | dir | payload                              | beat
//  ---------+-----+--------------------------------------+---------------------------
//  in_ch    | in  | kind, data_byte                      | one byte or a finish
//  out_ch   | out | digest_word, word_index, last_word   | one digest word, eight a msg
//
// a data beat is taken while idle; the 64th byte of a block starts the rounds
// and then the feed-forward add, both in the single shared round unit
// a finish pads one byte a cycle up to the block end, then runs the rounds and the
// feed-forward add for each of one or two blocks, then eight output beats
// in_ch.ready is high only while idle; out_ch.valid only while the digest is out
// reset (rst_n low, synchronous) loads the initial hash values and clears counts
// a stalled output holds its word; no input is taken until word 7 is taken
module sha256_stream_hasher (
  input logic      clk,
  input logic      rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  sha_state_t  state_r;
  sha_state_t  state_nxt;
  logic [5:0]  fill_r;
  logic [5:0]  fill_nxt;
  logic [60:0] len_r;
  logic [60:0] len_nxt;
  logic [5:0]  rnd_r;
  logic [5:0]  rnd_nxt;
  logic [2:0]  widx_r;
  logic [2:0]  widx_nxt;
  logic        pad_r;       // finish in progress
  logic        pad_nxt;
  logic        first_r;     // next pad byte is the 0x80 marker
  logic        first_nxt;
  logic        final_r;     // current padded block carries the length
  logic        final_nxt;

  sha_ctl_t    ctl;
  sha_word_t   w;
  sha_word_t   hv;
  logic        in_acc;
  logic        out_acc;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // bit length, big-endian into the last eight bytes of the final block
  assign len_bits = {len_r, 3'b000};
  assign len_byte = len_bits[{~fill_r[2:0], 3'b000} +: 8];
  assign pad_byte = first_r ? PAD_MARK :
                    (final_r && (fill_r >= LEN_POS)) ? len_byte : 8'h00;

  sha_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w_o (w)
  );

  sha_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w_i   (w),
    .hv_o  (hv)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_FINISH) begin
            state_nxt = ST_PAD;
          end else if (fill_r == FILL_LAST) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (pad_r) begin
          state_nxt = final_r ? ST_EMIT : ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc && (widx_r == WIDX_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs, datapath control and counters
  always_comb begin
    ctl            = '0;
    ctl.rnd        = rnd_r;
    ctl.expand     = (rnd_r[5:4] != 2'b00);
    ctl.widx       = widx_r;
    in_ch.ready    = 1'b0;
    out_ch.valid   = 1'b0;
    fill_nxt       = fill_r;
    len_nxt        = len_r;
    rnd_nxt        = rnd_r;
    widx_nxt       = widx_r;
    pad_nxt        = pad_r;
    first_nxt      = first_r;
    final_nxt      = final_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        // ready is high here, so valid alone marks an input beat
        if (in_ch.valid) begin
          if (in_ch.kind == KIND_DATA) begin
            ctl.shift_byte = 1'b1;
            ctl.byte_val   = in_ch.data_byte;
            ctl.wv_load    = (fill_r == FILL_LAST);
            fill_nxt       = fill_r + 6'd1;
            len_nxt        = len_r + 61'd1;
          end else begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
            final_nxt = (fill_r < LEN_POS);
          end
        end
      end
      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.byte_val   = pad_byte;
        ctl.wv_load    = (fill_r == FILL_LAST);
        first_nxt      = 1'b0;
        fill_nxt       = fill_r + 6'd1;
      end
      ST_ROUND: begin
        ctl.sched_step = 1'b1;
        ctl.wv_step    = 1'b1;
        rnd_nxt        = rnd_r + 6'd1;
      end
      ST_UPDATE: begin
        ctl.hv_add = 1'b1;
        if (pad_r) begin
          final_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        // valid is high here, so ready alone marks an output beat
        if (out_ch.ready) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == WIDX_LAST) begin
            ctl.hv_init = 1'b1;
            len_nxt     = '0;
            pad_nxt     = 1'b0;
            final_nxt   = 1'b0;
          end
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign out_ch.digest_word = hv;
  assign out_ch.word_index  = widx_r;
  assign out_ch.last_word   = (widx_r == WIDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      rnd_r   <= '0;
      widx_r  <= '0;
      pad_r   <= 1'b0;
      first_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

// File: hw/rtl/sha_sched.sv
// sha_sched: 512-bit block buffer that doubles as the rolling message schedule
// bytes shift in during fill, words rotate and expand during rounds
// depends on sha_pkg
module sha_sched (
  input  logic             clk,
  input  sha_pkg::sha_ctl_t ctl,
  output sha_pkg::sha_word_t w_o
);
  import sha_pkg::*;

  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  sha_word_t    w0;
  sha_word_t    w1;
  sha_word_t    w9;
  sha_word_t    w14;
  sha_word_t    wexp;

  // word k of the window sits at blk_r[511-32k -: 32]
  assign w0   = blk_r[511:480];
  assign w1   = blk_r[479:448];
  assign w9   = blk_r[223:192];
  assign w14  = blk_r[63:32];
  assign wexp = w0 + ssig0(w1) + w9 + ssig1(w14);
  assign w_o  = ctl.expand ? wexp : w0;

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.shift_byte) begin
      blk_nxt = {blk_r[503:0], ctl.byte_val};
    end else if (ctl.sched_step) begin
      blk_nxt = {blk_r[479:0], w_o};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// File: hw/rtl/sha_round.sv
// sha_round: shared round unit with working variables and chaining state
// one compression round a cycle, feed-forward add, digest word read-out
// depends on sha_pkg
module sha_round (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_ctl_t  ctl,
  input  sha_pkg::sha_word_t w_i,
  output sha_pkg::sha_word_t hv_o
);
  import sha_pkg::*;

  sha_word_t wv_r [8];
  sha_word_t hv_r [8];
  sha_word_t t1;
  sha_word_t t2;
  sha_word_t ch;
  sha_word_t mj;

  assign ch   = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign mj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1   = wv_r[7] + bsig1(wv_r[4]) + ch + round_k(ctl.rnd) + w_i;
  assign t2   = bsig0(wv_r[0]) + mj;
  assign hv_o = hv_r[ctl.widx];

  always_ff @(posedge clk) begin
    if (ctl.wv_load) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= hv_r[i];
      end
    end else if (ctl.wv_step) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.hv_init) begin
      for (int i = 0; i < 8; i++) begin
        hv_r[i] <= init_h(3'(i));
      end
    end else if (ctl.hv_add) begin
      for (int i = 0; i < 8; i++) begin
        hv_r[i] <= hv_r[i] + wv_r[i];
      end
    end
  end

endmodule

// File: hw/rtl/sha_chk.sv
// sha_chk: port-level checks of the sha-256 stream hasher, bound to the top level
// watches both channels over time
// depends on sha_pkg and sha256_stream_hasher
module sha_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input sha_pkg::sha_word_t digest_word,
  input logic [2:0]        word_index,
  input logic              last_word
);
  import sha_pkg::*;

  // the digest is never shown while input is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest beat valid");

  // a stalled digest beat keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("stalled digest beat changed");

  // words follow in order until the last one
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  // after the last word the block is idle again
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("not idle after last digest word");

  // a finish beat closes the input until the digest is out
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_FINISH) |=> !in_ready)
    else $error("input taken during finish");

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_kind     (in_ch.kind),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);
